### design/tsda_pkg.sv
// Package for the threshold stack dip area block: constants, the 0.85^k table
// and the per-level threshold function. No dependencies.
`timescale 1ns / 1ps
package tsda_pkg;
    localparam int NUM_LEVELS_DEF = 10;
    localparam int MAX_LEN_DEF    = 1024;
    localparam int SAMPLE_W = 8;
    localparam int THR_W    = 16;
    localparam int POS_Q_W  = 18;
    localparam int WIDTH_W  = 18;
    localparam int AREA_W   = 22;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;
    localparam logic [AREA_W-1:0]  AREA_MAX  = '1;
    localparam logic [7:0] THRESHOLD_RESET = 8'd128;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_SUM
    } tsda_state_t;

    function automatic logic [16:0] pow085(input logic [3:0] k);
        logic [16:0] f;
        case (k)
            4'd0:  f = 17'd65536;
            4'd1:  f = 17'd55706;
            4'd2:  f = 17'd47350;
            4'd3:  f = 17'd40247;
            4'd4:  f = 17'd34210;
            4'd5:  f = 17'd29079;
            4'd6:  f = 17'd24717;
            4'd7:  f = 17'd21009;
            4'd8:  f = 17'd17858;
            4'd9:  f = 17'd15179;
            4'd10: f = 17'd12902;
            4'd11: f = 17'd10967;
            4'd12: f = 17'd9322;
            4'd13: f = 17'd7924;
            4'd14: f = 17'd6735;
            default: f = 17'd5725;
        endcase
        return f;
    endfunction

    // Rounded Q8.8 level threshold from the 8-bit top threshold.
    function automatic logic [THR_W-1:0] level_thr(input logic [7:0] thr,
                                                   input logic [3:0] k);
        logic [24:0] p;
        p = thr * pow085(k) + 25'd128;
        return p[23:8];
    endfunction
endpackage

### design/tsda_if.sv
// Valid/ready channel interfaces for sample requests and area results.
// No dependencies.
`timescale 1ns / 1ps
interface tsda_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    logic       last;
    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

interface tsda_out_if;
    logic        valid;
    logic        ready;
    logic [21:0] area;
    logic        overflow;
    modport source (output valid, area, overflow, input ready);
    modport sink   (input valid, area, overflow, output ready);
endinterface

### design/tsda_cell.sv
// One threshold level cell: below flag, run start, width accumulator, and a
// restoring divider for the crossing offset. Depends on tsda_pkg.
`timescale 1ns / 1ps
module tsda_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [3:0]                    level,
    input  logic [7:0]                    threshold,
    input  logic                          start,     // sample accepted
    input  logic [7:0]                    sample,
    input  logic [7:0]                    prev,
    input  logic [9:0]                    pos,
    input  logic                          last,
    input  logic                          div_step,  // one quotient bit
    input  logic                          finish,    // apply pending crossing
    input  logic                          clear,
    input  logic                          shift,     // sum chain moves
    input  logic [tsda_pkg::WIDTH_W-1:0]  width_in,
    output logic [tsda_pkg::WIDTH_W-1:0]  width_out
);
    import tsda_pkg::*;

    logic                 below_reg, below_next;
    logic [POS_Q_W-1:0]   start_reg, start_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic                 pend_reg, pend_next;    // crossing waits for offset
    logic                 pdown_reg, pdown_next;  // pending is a down crossing
    logic [16:0]          rem_reg, rem_next;
    logic [8:0]           den_reg, den_next;
    logic [16:0]          quo_reg, quo_next;
    logic [POS_Q_W-1:0]   ix_reg, ix_next;
    logic                 plast_reg, plast_next;
    logic [16:0]          num_reg, num_next;

    logic [THR_W-1:0]  t;
    logic [16:0]       g8;
    logic signed [9:0] gp;
    logic              down, up;
    logic [POS_Q_W-1:0] ix, off, xpos;
    logic [16:0]       trial;

    function automatic logic [WIDTH_W-1:0] addw(input logic [WIDTH_W-1:0] w,
                                                input logic [POS_Q_W-1:0] e,
                                                input logic [POS_Q_W-1:0] s);
        logic [POS_Q_W-1:0] d;
        logic [WIDTH_W:0]   sum;
        d = (e > s) ? e - s : '0;
        sum = {1'b0, w} + {1'b0, d};
        return sum[WIDTH_W] ? WIDTH_MAX : sum[WIDTH_W-1:0];
    endfunction

    always_comb
    begin
        t  = level_thr(threshold, level);
        g8 = {1'b0, sample, 8'd0};
        gp = $signed({2'b00, sample}) - $signed({2'b00, prev});
        ix = {pos, 8'd0};
        down = !below_reg && (g8 < {1'b0, t});
        up   = below_reg && (g8 > {1'b0, t});
        off  = (quo_reg > 17'd256) ? POS_Q_W'(256) : POS_Q_W'(quo_reg);
        xpos = (ix_reg > off) ? ix_reg - off : '0;
        trial = {rem_reg[15:0], num_reg[16]};

        below_next = below_reg;
        start_next = start_reg;
        width_next = width_reg;
        pend_next  = pend_reg;
        pdown_next = pdown_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        ix_next    = ix_reg;
        plast_next = plast_reg;
        num_next   = num_reg;

        if (start)
        begin
            ix_next = ix;
            plast_next = last;
            pend_next = 1'b0;
            quo_next = '0;
            rem_next = '0;
            num_next = '0;
            if (down)
            begin
                below_next = 1'b1;
                if (pos == '0)
                    start_next = '0;
                else if (gp < 0)
                begin
                    pend_next = 1'b1;
                    pdown_next = 1'b1;
                    num_next = {1'b0, t} - g8;
                    den_next = 9'(-gp);
                end
                else
                    start_next = ix;
                // A run opened on the last sample closes at once; its width is
                // the crossing offset, added when the offset is known.
                if (last)
                    below_next = 1'b0;
            end
            else if (up)
            begin
                below_next = 1'b0;
                if (last || gp <= 0)
                    width_next = addw(width_reg, ix, start_reg);
                else
                begin
                    pend_next = 1'b1;
                    pdown_next = 1'b0;
                    num_next = g8 - {1'b0, t};
                    den_next = 9'(gp);
                end
            end
            else if (last && below_reg)
            begin
                below_next = 1'b0;
                width_next = addw(width_reg, ix, start_reg);
            end
        end
        else if (div_step && pend_reg)
        begin
            // Numerator bits enter the partial remainder from the top.
            num_next = {num_reg[15:0], 1'b0};
            if (trial >= {8'd0, den_reg})
            begin
                quo_next = {quo_reg[15:0], 1'b1};
                rem_next = trial - {8'd0, den_reg};
            end
            else
            begin
                quo_next = {quo_reg[15:0], 1'b0};
                rem_next = trial;
            end
        end
        else if (finish && pend_reg)
        begin
            pend_next = 1'b0;
            if (pdown_reg)
            begin
                start_next = xpos;
                if (plast_reg)
                    width_next = addw(width_reg, ix_reg, xpos);
            end
            else
                width_next = addw(width_reg, xpos, start_reg);
        end

        if (shift)
            width_next = width_in;
        if (clear)
        begin
            below_next = 1'b0;
            start_next = '0;
            width_next = '0;
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            below_reg <= 1'b0;
            start_reg <= '0;
            width_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            below_reg <= below_next;
            start_reg <= start_next;
            width_reg <= width_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pdown_reg <= pdown_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        ix_reg    <= ix_next;
        plast_reg <= plast_next;
        num_reg   <= num_next;
    end

    assign width_out = width_reg;
endmodule

### design/tsda_ctrl.sv
// Sequencer for one sample: accept, offset division, and the end-of-line
// area sum through the cell chain. Depends on tsda_pkg.
`timescale 1ns / 1ps
module tsda_ctrl #(
    parameter int NUM_LEVELS = tsda_pkg::NUM_LEVELS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic last,
    input  logic out_fire,
    output logic in_ready,
    output logic div_step,
    output logic finish,
    output logic shift,
    output logic sum_first,
    output logic sum_done
);
    import tsda_pkg::*;
    localparam int CW = $clog2(NUM_LEVELS + 18);

    tsda_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (in_fire)
                begin
                    state_next = ST_DIV;
                    cnt_next = '0;
                    last_next = last;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(17))
                begin
                    cnt_next = '0;
                    state_next = last_reg ? ST_SUM : ST_RUN;
                end
            end
            ST_SUM:
            begin
                if (cnt_reg != CW'(NUM_LEVELS))
                    cnt_next = cnt_reg + 1'b1;
                else if (out_fire)
                    state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_RUN);
        div_step  = (state_reg == ST_DIV) && (cnt_reg != CW'(17));
        finish    = (state_reg == ST_DIV) && (cnt_reg == CW'(17));
        shift     = (state_reg == ST_SUM) && (cnt_reg != CW'(NUM_LEVELS));
        sum_first = (state_reg == ST_SUM) && (cnt_reg == '0);
        sum_done  = (state_reg == ST_SUM) && (cnt_reg == CW'(NUM_LEVELS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            cnt_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            last_reg <= last_next;
        end
    end
endmodule

### design/threshold_stack_dip_area_top.sv
// Threshold stack dip area: one cell per level in a chain, sequencer and sum.
// Per sample: a 17-step shared-position offset divide in each cell, then an
// apply step; a last sample then shifts the widths out into the area adder
// and registers the result. One sample in flight at a time.
// rst_n (async, low) sets threshold 128 and clears all line state.
// Depends on tsda_pkg, tsda_if, tsda_cell, tsda_ctrl.
`timescale 1ns / 1ps
module threshold_stack_dip_area_top #(
    parameter int NUM_LEVELS = tsda_pkg::NUM_LEVELS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    tsda_in_if.sink    in_ch,
    tsda_out_if.source out_ch
);
    import tsda_pkg::*;
    localparam int MAX_LEN = MAX_LEN_DEF;
    localparam int PW = $clog2(MAX_LEN);

    logic [7:0]    threshold_reg;
    logic [7:0]    prev_reg;
    logic [PW-1:0] pos_reg;
    logic          ovf_reg;
    logic [AREA_W-1:0] area_reg;
    logic          oval_reg;
    logic          in_fire, out_fire;
    logic          div_step, finish, shift, sum_first, sum_done;
    logic          clear;
    logic [WIDTH_W-1:0] chain [NUM_LEVELS+1];
    logic [9:0]    pos10;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign chain[NUM_LEVELS] = '0;
    assign pos10 = 10'(pos_reg);
    assign clear = out_fire;

    tsda_ctrl #(.NUM_LEVELS(NUM_LEVELS)) u_ctrl (
        .clk, .rst_n, .in_fire, .last(in_ch.last), .out_fire,
        .in_ready(in_ch.ready), .div_step, .finish, .shift, .sum_first, .sum_done
    );

    for (genvar k = 0; k < NUM_LEVELS; k++)
    begin : g_cell
        tsda_cell u_cell (
            .clk, .rst_n, .level(4'(k)), .threshold(threshold_reg),
            .start(in_fire), .sample(in_ch.sample), .prev(prev_reg),
            .pos(pos10), .last(in_ch.last), .div_step, .finish, .clear,
            .shift, .width_in(chain[k+1]), .width_out(chain[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            prev_reg <= '0;
            pos_reg <= '0;
            ovf_reg <= 1'b0;
            area_reg <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                threshold_reg <= cfg_wdata;
            if (in_fire)
            begin
                prev_reg <= in_ch.sample;
                if (!in_ch.last)
                begin
                    if (pos_reg >= PW'(MAX_LEN - 1))
                        ovf_reg <= 1'b1;
                    else
                        pos_reg <= pos_reg + 1'b1;
                end
            end
            if (shift)
            begin
                if (sum_first)
                    area_reg <= AREA_W'(chain[0]);
                else if ({1'b0, area_reg} + (AREA_W+1)'(chain[0]) > (AREA_W+1)'(AREA_MAX))
                    area_reg <= AREA_MAX;
                else
                    area_reg <= area_reg + AREA_W'(chain[0]);
            end
            if (sum_done && !oval_reg && !out_fire)
                oval_reg <= 1'b1;
            if (out_fire)
            begin
                oval_reg <= 1'b0;
                prev_reg <= '0;
                pos_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid    = oval_reg;
    assign out_ch.area     = area_reg;
    assign out_ch.overflow = ovf_reg;

    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken while result pending");
    a_out_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(sum_done))
        else $error("result without sum");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_LEN - 1))
        else $error("position beyond limit");
endmodule

### sim/tb_threshold_stack_dip_area_top.sv
// Testbench for threshold_stack_dip_area_top: drives profile lines as sample
// requests, predicts each line's dip area in a behavioral model and checks results.
// Depends on tsda_pkg, tsda_if and the design files.
`timescale 1ns / 1ps
module tb_threshold_stack_dip_area_top;
    import tsda_pkg::*;

    localparam int NLEV    = NUM_LEVELS_DEF;
    localparam int LINEMAX = MAX_LEN_DEF;
    localparam int WDOG    = 20000;
    localparam int DRAIN   = 100;

    typedef struct packed {
        logic [21:0] area;
        logic        overflow;
    } area_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;

    tsda_in_if  in_ch();
    tsda_out_if out_ch();

    threshold_stack_dip_area_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state for one profile line.
    logic [7:0]  top_thr;
    int unsigned lvl_thr [NLEV];
    bit          under [NLEV];
    int unsigned dip_begin [NLEV];
    int unsigned dip_width [NLEV];
    int unsigned prev_gray;
    int unsigned line_pos;
    bit          line_ovf;

    area_result_t expected_areas[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  stall_on = 1'b0;
    bit  allow_gaps = 1'b1;

    function automatic int unsigned q8_offset(int num, int den);
        int unsigned r;
        if (den <= 0 || num <= 0)
            return 0;
        r = num / den;
        return (r > 256) ? 256 : r;
    endfunction

    function automatic int unsigned sat_sub(int unsigned a, int unsigned b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic void set_levels();
        int unsigned f [16] = '{65536, 55706, 47350, 40247, 34210, 29079, 24717,
            21009, 17858, 15179, 12902, 10967, 9322, 7924, 6735, 5725};
        for (int k = 0; k < NLEV; k++)
            lvl_thr[k] = (top_thr * f[k % 16] + 128) >> 8;
    endfunction

    function automatic void clear_line();
        for (int k = 0; k < NLEV; k++)
        begin
            under[k] = 0;
            dip_begin[k] = 0;
            dip_width[k] = 0;
        end
        prev_gray = 0;
        line_pos = 0;
        line_ovf = 0;
    endfunction

    function automatic void close_dip(int k, int unsigned stop);
        int unsigned w;
        w = dip_width[k] + sat_sub(stop, dip_begin[k]);
        dip_width[k] = (w > 262143) ? 262143 : w;
    endfunction

    function automatic void predict_area(logic [7:0] g, logic last);
        int unsigned ix;
        int g8;
        int gp;
        int t;
        int unsigned sum;
        area_result_t r;
        ix = line_pos * 256;
        g8 = g * 256;
        gp = int'(g) - int'(prev_gray);
        sum = 0;
        for (int k = 0; k < NLEV; k++)
        begin
            t = lvl_thr[k];
            if (!under[k] && g8 < t)
            begin
                dip_begin[k] = (line_pos == 0) ? 0 : sat_sub(ix, q8_offset(t - g8, -gp));
                under[k] = 1;
            end
            else if (under[k] && g8 > t)
            begin
                close_dip(k, last ? ix : sat_sub(ix, q8_offset(g8 - t, gp)));
                under[k] = 0;
            end
            if (last && under[k])
            begin
                close_dip(k, ix);
                under[k] = 0;
            end
        end
        prev_gray = g;
        if (!last)
        begin
            if (line_pos >= LINEMAX - 1)
            begin
                line_pos = LINEMAX - 1;
                line_ovf = 1;
            end
            else
                line_pos++;
            return;
        end
        for (int k = 0; k < NLEV; k++)
        begin
            sum += dip_width[k];
            if (sum > 4194303)
                sum = 4194303;
        end
        r.area = sum[21:0];
        r.overflow = line_ovf;
        expected_areas.push_back(r);
        clear_line();
    endfunction

    // Send one sample request, with random gaps in bursts when allowed.
    // Valid stays high after an accept until the next request, a gap or wait_idle replaces it.
    int burst_left = 0;
    task automatic send_sample(logic [7:0] g, logic last);
        int gap;
        if (allow_gaps && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_ch.valid  <= 1'b1;
        in_ch.sample <= g;
        in_ch.last   <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_area(g, last);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_areas.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_threshold(logic [7:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        top_thr = v;
        set_levels();
    endtask

    // A well-formed dip: bright shoulders around a valley of random depth.
    task automatic send_dip_line(int len);
        int c;
        int d;
        c = $urandom_range(0, len - 1);
        d = $urandom_range(1, 255);
        for (int i = 0; i < len; i++)
        begin
            int v;
            v = 255 - (d * (len - ((i > c) ? i - c : c - i))) / len
                - $urandom_range(0, 20);
            if (v < 0)
                v = 0;
            send_sample(v[7:0], i == len - 1);
        end
    endtask

    task automatic test_directed();
        send_sample(8'd255, 1'b1);
        send_sample(8'd0, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd0, 1'b1);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd128, 1'b0);
        send_sample(8'd127, 1'b0);
        send_sample(8'd255, 1'b1);
        send_sample(8'd200, 1'b0);
        send_sample(8'd10, 1'b0);
        send_sample(8'd250, 1'b1);
        // Threshold change in the middle of a line: flat crossing.
        send_sample(8'd60, 1'b0);
        send_sample(8'd60, 1'b0);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= 8'd50;
        @(posedge clk);
        cfg_we <= 1'b0;
        top_thr = 8'd50;
        set_levels();
        send_sample(8'd60, 1'b0);
        send_sample(8'd60, 1'b1);
        write_threshold(8'd128);
    endtask

    task automatic test_long_line();
        for (int i = 0; i < LINEMAX + 5; i++)
            send_sample((i % 64 < 32) ? 8'd20 : 8'd240, i == LINEMAX + 4);
    endtask

    task automatic test_random(int n);
        int sent;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                int len;
                len = $urandom_range(1, 24);
                send_dip_line(len);
                sent += len;
            end
            else
            begin
                send_sample(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
                sent++;
            end
        end
        send_sample(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_thresholds();
        logic [7:0] vals [5] = '{8'd0, 8'd255, 8'd1, 8'd200, 8'd128};
        foreach (vals[j])
        begin
            write_threshold(vals[j]);
            test_random(150);
        end
    endtask

    // Result check and receiver stall pattern.
    always @(posedge clk)
    begin
        area_result_t e;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_areas.size() == 0)
                begin
                    $error("unexpected result area=%0d", out_ch.area);
                    errors++;
                end
                else
                begin
                    e = expected_areas.pop_front();
                    if (out_ch.area !== e.area)
                    begin
                        $error("area expected %0d actual %0d", e.area, out_ch.area);
                        errors++;
                    end
                    if (out_ch.overflow !== e.overflow)
                    begin
                        $error("overflow expected %0d actual %0d", e.overflow,
                               out_ch.overflow);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 15) == 0)
                stall_on <= !stall_on;
            out_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WDOG)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.sample = 8'd0;
        in_ch.last   = 1'b0;
        out_ch.ready = 1'b0;
        top_thr = THRESHOLD_RESET;
        set_levels();
        clear_line();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_line();
        allow_gaps = 1'b0;
        test_random(200);
        allow_gaps = 1'b1;
        test_thresholds();
        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
